>>> rtl/core/sb2da_pkg.sv
// shared constants and types for the signed binary to decimal ascii unit
`timescale 1ns / 1ps

package sb2da_pkg;

    // widths of the request and result fields
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 6;
    localparam int DIGIT_W = 4;

    // a 32-bit magnitude has at most ten decimal digits
    localparam int NUM_DIGITS = 10;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    // reciprocal of ten: floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for any 32-bit x
    localparam logic [VALUE_W-1:0] DIV10_MUL   = 32'hCCCC_CCCD;
    localparam int                 DIV10_SHIFT = 35;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

endpackage

>>> rtl/core/signed_binary_to_decimal_ascii_unit.sv
// signed 32-bit integer to decimal ascii text, one character per result request
`timescale 1ns / 1ps

//  channel | dir | tdata (low bit up)        | tlast      | handshake
//  s_      | in  | [31:0] value (signed)     | -          | s_tvalid / s_tready
//  m_      | out | [5:0] char_code, [7:6] 0  | last_char  | m_tvalid / m_tready
//
//  An accepted value is registered in stage 0, then runs through ten divide-by-ten stages
//  (one reciprocal multiply each) and is then loaded into the character serializer.
//  The serializer sends one character per cycle while m_tready is high; a value's text
//  has 1 to 11 characters, and the serializer sets the sustained rate.
//  A held result stalls the whole digit pipeline once its last stage holds a value, and
//  s_tready drops only while that last stage waits for a busy serializer.
//  aresetn (synchronous, active low) clears every valid bit; no clearing pass is needed.

module signed_binary_to_decimal_ascii_unit
    import sb2da_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] char_code, [7:6] zero
    output logic        m_tlast    // last_char
);

    // digit pipeline: stage 0 holds the magnitude, stage k holds k digits found
    logic [NUM_DIGITS:0]              vld_reg;
    logic [NUM_DIGITS:0]              vld_next;
    logic [NUM_DIGITS:0]              neg_reg;
    logic [NUM_DIGITS:0]              neg_next;
    logic [VALUE_W-1:0]               quo_reg  [0:NUM_DIGITS];
    logic [VALUE_W-1:0]               quo_next [0:NUM_DIGITS];
    digit_vec_t                       dig_reg  [0:NUM_DIGITS];
    digit_vec_t                       dig_next [0:NUM_DIGITS];
    logic [2*VALUE_W-1:0]             prod_w   [1:NUM_DIGITS];
    logic [VALUE_W-1:0]               q_w      [1:NUM_DIGITS];
    digit_t                           ten_q_w  [1:NUM_DIGITS];

    // character serializer
    logic       ser_vld_reg;
    logic       ser_vld_next;
    logic       ser_neg_reg;
    logic       ser_neg_next;
    logic [3:0] ser_idx_reg;
    logic [3:0] ser_idx_next;
    digit_vec_t ser_dig_reg;
    digit_vec_t ser_dig_next;

    logic       pipe_en;
    logic       can_load;
    logic       load;
    logic       take;
    logic [3:0] top_idx;
    digit_t     cur_dig;
    logic [CHAR_W-1:0] char_code;

    // output side
    assign cur_dig   = ser_dig_reg[ser_idx_reg];
    assign char_code = ser_neg_reg ? CHAR_MINUS : (CHAR_ZERO + {2'b00, cur_dig});
    assign m_tvalid  = ser_vld_reg;
    assign m_tdata   = {2'b00, char_code};
    assign m_tlast   = ~ser_neg_reg & (ser_idx_reg == 4'd0);
    assign take      = m_tvalid & m_tready;

    // pipeline advance and serializer load
    assign can_load = ~ser_vld_reg | (take & m_tlast);
    assign pipe_en  = ~vld_reg[NUM_DIGITS] | can_load;
    assign load     = vld_reg[NUM_DIGITS] & can_load;
    assign s_tready = pipe_en;

    // per-stage next values: one reciprocal multiply and a 4-bit remainder each
    always_comb begin
        vld_next[0] = s_tvalid;
        neg_next[0] = s_tdata[31];
        quo_next[0] = s_tdata[31] ? (~s_tdata + 32'd1) : s_tdata;
        dig_next[0] = '0;
        for (int k = 1; k <= NUM_DIGITS; k++) begin
            prod_w[k]   = {32'd0, quo_reg[k-1]} * {32'd0, DIV10_MUL};
            q_w[k]      = {{DIV10_SHIFT-VALUE_W{1'b0}}, prod_w[k][2*VALUE_W-1:DIV10_SHIFT]};
            ten_q_w[k]  = {q_w[k][0], 3'b000} + {q_w[k][2:0], 1'b0};
            vld_next[k] = vld_reg[k-1];
            neg_next[k] = neg_reg[k-1];
            quo_next[k] = q_w[k];
            dig_next[k] = dig_reg[k-1];
            dig_next[k][k-1] = quo_reg[k-1][3:0] - ten_q_w[k];
        end
    end

    // highest nonzero digit gives the text length
    always_comb begin
        top_idx = 4'd0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (dig_reg[NUM_DIGITS][k] != 4'd0) begin
                top_idx = 4'(k);
            end
        end
    end

    // serializer next state
    always_comb begin
        ser_vld_next = ser_vld_reg;
        ser_neg_next = ser_neg_reg;
        ser_idx_next = ser_idx_reg;
        ser_dig_next = ser_dig_reg;
        priority if (load) begin
            ser_vld_next = 1'b1;
            ser_neg_next = neg_reg[NUM_DIGITS];
            ser_idx_next = top_idx;
            ser_dig_next = dig_reg[NUM_DIGITS];
        end else if (take) begin
            priority if (ser_neg_reg) begin
                ser_neg_next = 1'b0;
            end else if (ser_idx_reg == 4'd0) begin
                ser_vld_next = 1'b0;
            end else begin
                ser_idx_next = ser_idx_reg - 4'd1;
            end
        end else begin
            // hold
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            ser_vld_reg <= 1'b0;
        end else begin
            if (pipe_en) begin
                vld_reg <= vld_next;
            end
            ser_vld_reg <= ser_vld_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            neg_reg <= neg_next;
            for (int k = 0; k <= NUM_DIGITS; k++) begin
                quo_reg[k] <= quo_next[k];
                dig_reg[k] <= dig_next[k];
            end
        end
        ser_neg_reg <= ser_neg_next;
        ser_idx_reg <= ser_idx_next;
        ser_dig_reg <= ser_dig_next;
    end

`ifndef NO_ASSERTIONS
    // a minus sign is never the final character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[5:0] != CHAR_MINUS))
        else $error("minus sign marked as last character");

    // the input only stalls behind a full last stage and a busy serializer
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (vld_reg[NUM_DIGITS] && ser_vld_reg))
        else $error("input stalled without cause");

    // a loaded text always starts at one of the ten digit slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (ser_idx_reg <= 4'(NUM_DIGITS - 1)))
        else $error("serializer index out of range");

    // each taken digit character that is not the last counts the serializer index down by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(take) && !$past(load) && !$past(ser_neg_reg) && !$past(m_tlast))
            |-> (ser_idx_reg == $past(ser_idx_reg) - 4'd1))
        else $error("serializer skipped a character");

    // reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

>>> tb/signed_binary_to_decimal_ascii_unit_test.sv
// testbench for the signed binary to decimal ascii unit: directed, random and backpressure tests
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_unit_test;
    import sb2da_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int IDLE_PCT    = 23;
    localparam int END_WAIT    = 40;

    // one expected character of a value's text
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } text_char_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata  = '0;   // [31:0] value
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;         // [5:0] char_code, [7:6] zero
    logic               m_tlast;         // last_char

    text_char_t pending_chars[$];
    int         error_count       = 0;
    int         cycle_count       = 0;
    int         sink_hold_cycles  = 0;
    bit         src_idle_on       = 1'b1;
    bit         sink_idle_on      = 1'b1;

    signed_binary_to_decimal_ascii_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run time limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side ready: random idling, or a long hold when one is asked for
    always @(posedge aclk) begin
        if (sink_hold_cycles > 0) begin
            sink_hold_cycles--;
            m_tready <= 1'b0;
        end else if (sink_idle_on) begin
            m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each accepted character with the oldest expected one
    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected character: code %0d last %0b", m_tdata[5:0], m_tlast);
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata[5:0] !== want.char_code || m_tlast !== want.last_char
                        || m_tdata[7:6] !== 2'b00) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch: expected code %0d last %0b, got tdata %0d last %0b",
                                 want.char_code, want.last_char, m_tdata, m_tlast);
                end
            end
        end
    end

    // decimal text of a signed value, most significant character first
    function automatic void predict_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] mag;
        digit_t             digits[NUM_DIGITS];
        int                 ndig;
        text_char_t         c;
        mag  = value[VALUE_W-1] ? (~value + 1'b1) : value;
        ndig = 0;
        do begin
            digits[ndig] = digit_t'(mag % 10);
            mag          = mag / 10;
            ndig++;
        end while (mag != 0);
        if (value[VALUE_W-1]) begin
            c.char_code = CHAR_MINUS;
            c.last_char = 1'b0;
            pending_chars.push_back(c);
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            c.char_code = CHAR_ZERO + CHAR_W'(digits[i]);
            c.last_char = (i == 0);
            pending_chars.push_back(c);
        end
    endfunction

    // offer one value, with an optional gap, and record its text once accepted
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        if (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_text(value);
    endtask

    // stop offering and wait until every expected character has arrived
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    // random value with a random digit count and sign, sometimes any 32-bit pattern
    function automatic logic [VALUE_W-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     ndig;
        bit     neg;
        if ($urandom_range(4) == 0)
            return $urandom;
        ndig = $urandom_range(1, NUM_DIGITS);
        neg  = $urandom_range(1);
        lo   = 1;
        for (int i = 1; i < ndig; i++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1) lo = 0;
        if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
        mag = lo + longint'($urandom_range(int'(hi - lo)));
        return neg ? VALUE_W'(-mag) : VALUE_W'(mag);
    endfunction

    // extremes, digit-count boundaries and alternating bit patterns
    task automatic test_directed();
        logic [VALUE_W-1:0] vals[$];
        vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'd2147483647, 32'h8000_0000, -32'sd2147483647, 32'd1000000000,
                 -32'sd1000000000, 32'd999999999, -32'sd999999999, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'd1234567890, -32'sd123456789, 32'd7, -32'sd9};
        foreach (vals[i]) send_value(vals[i]);
        wait_for_drain();
    endtask

    // random values with idling on both sides
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) send_value(random_value());
    endtask

    // no idling on either side
    task automatic test_back_to_back(input int count);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        for (int i = 0; i < count; i++) send_value(random_value());
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // receiver holds off long enough that the block fills and stalls its input
    task automatic test_sink_hold(input int count);
        src_idle_on      = 1'b0;
        sink_hold_cycles = 300;
        for (int i = 0; i < count; i++) send_value(random_value());
        src_idle_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(200);
        test_back_to_back(60);
        test_sink_hold(40);
        wait_for_drain();
        test_random(40);

        wait_for_drain();
        repeat (END_WAIT) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
